// ===== src/itt_pkg.sv =====
`timescale 1ns / 1ps
// itt_pkg: shared types and constants for the interval task timer table.
// No dependencies; compiled first.
package itt_pkg;

  localparam int MaxTasksDef = 16;  // default table depth
  localparam int MaxResults  = 16;  // fired words per tick, at most
  localparam int KindW       = 2;
  localparam int CallbackW   = 16;
  localparam int ArgumentW   = 32;
  localparam int TimeW       = 64;

  typedef enum logic [KindW-1:0] {
    KIND_PERIODIC = 2'd0,
    KIND_ONCE     = 2'd1,
    KIND_DELAYED  = 2'd2,
    KIND_TICK     = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    RES_FIRED    = 2'd0,
    RES_ACCEPTED = 2'd1,
    RES_REJECTED = 2'd2
  } res_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [CallbackW-1:0] callback;
    logic [ArgumentW-1:0] argument;
    logic [TimeW-1:0]     interval;
    logic [TimeW-1:0]     last_time;
    logic                 one_shot;
  } entry_t;

  typedef struct packed {
    res_kind_t            kind;
    logic [CallbackW-1:0] callback;
    logic [ArgumentW-1:0] argument;
    logic                 last;
  } result_t;

endpackage

// ===== src/itt_if.sv =====
`timescale 1ns / 1ps
// itt_in_if / itt_out_if: valid/ready channels for request and result words.
// Depends on itt_pkg for field widths.
interface itt_in_if;
  import itt_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [KindW-1:0]     kind;
  logic [CallbackW-1:0] callback_id;
  logic [ArgumentW-1:0] argument;
  logic [TimeW-1:0]     interval;
  logic [TimeW-1:0]     now;

  modport source (output valid, kind, callback_id, argument, interval, now, input ready);
  modport sink (input valid, kind, callback_id, argument, interval, now, output ready);
endinterface

interface itt_out_if;
  import itt_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [1:0]           result_kind;
  logic [CallbackW-1:0] fired_callback;
  logic [ArgumentW-1:0] fired_argument;
  logic                 last;

  modport source (output valid, result_kind, fired_callback, fired_argument, last,
                  input ready);
  modport sink (input valid, result_kind, fired_callback, fired_argument, last,
                output ready);
endinterface

// ===== src/itt_core.sv =====
`timescale 1ns / 1ps
// itt_core: task memory, insert path and tick scan with in-place compaction.
// Depends on itt_pkg and itt_in_if.
module itt_core #(
  parameter int MAX_TASKS = itt_pkg::MaxTasksDef
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            halted,
  itt_in_if.sink          req,
  input  logic            out_free,
  output logic            push,
  output itt_pkg::result_t res
);
  import itt_pkg::*;

  localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int RW = $clog2(MaxResults + 1);

  state_t             state, state_next;
  logic [CW-1:0]      count, count_next;
  logic [CW-1:0]      rd_ptr, rd_ptr_next;
  logic [CW-1:0]      wr_ptr, wr_ptr_next;
  logic [RW-1:0]      nres, nres_next;
  logic [TimeW-1:0]   now_q, now_next;
  result_t            held, held_next;
  logic               held_valid, held_valid_next;

  // task memory, registered read
  entry_t             mem [MAX_TASKS];
  entry_t             rdata;
  logic               we, re;
  logic [AW-1:0]      waddr, raddr;
  entry_t             wdata;

  logic               accept, due, fire, keep, stall;
  logic [TimeW-1:0]   elapsed;
  kind_t              kind;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      held_valid <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      held_valid <= held_valid_next;
    end
    rd_ptr <= rd_ptr_next;
    wr_ptr <= wr_ptr_next;
    nres   <= nres_next;
    now_q  <= now_next;
    held   <= held_next;
  end

  assign kind    = kind_t'(req.kind);
  assign elapsed = now_q - rdata.last_time;
  assign due     = (elapsed >= rdata.interval);
  assign fire    = due && (nres < RW'(MaxResults));
  assign keep    = !(fire && rdata.one_shot);
  assign stall   = fire && held_valid && !out_free;

  always_comb begin
    state_next      = state;
    count_next      = count;
    rd_ptr_next     = rd_ptr;
    wr_ptr_next     = wr_ptr;
    nres_next       = nres;
    now_next        = now_q;
    held_next       = held;
    held_valid_next = held_valid;
    we              = 1'b0;
    re              = 1'b0;
    waddr           = wr_ptr[AW-1:0];
    raddr           = rd_ptr[AW-1:0];
    wdata           = rdata;
    push            = 1'b0;
    res             = held;
    req.ready       = (state == ST_IDLE);
    accept          = req.valid && req.ready;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (kind != KIND_TICK) begin
            held_next       = '{kind: RES_ACCEPTED, callback: '0, argument: '0, last: 1'b1};
            held_valid_next = 1'b1;
            state_next      = ST_FLUSH;
            if (count >= CW'(MAX_TASKS)) begin
              held_next.kind = RES_REJECTED;
            end else begin
              we                 = 1'b1;
              waddr              = count[AW-1:0];
              wdata.callback     = req.callback_id;
              wdata.last_time    = req.now;
              wdata.argument     = (kind == KIND_PERIODIC) ? req.argument : '0;
              wdata.interval     = (kind == KIND_ONCE) ? '0 : req.interval;
              wdata.one_shot     = (kind != KIND_PERIODIC);
              count_next         = count + 1'b1;
            end
          end else if (!halted && count != '0) begin
            re          = 1'b1;
            raddr       = '0;
            rd_ptr_next = CW'(1);
            wr_ptr_next = '0;
            nres_next   = '0;
            now_next    = req.now;
            state_next  = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // rdata holds entry rd_ptr-1; survivors move down to wr_ptr
        if (!stall) begin
          if (fire) begin
            nres_next = nres + 1'b1;
            if (held_valid) push = 1'b1;
            held_next = '{kind: RES_FIRED, callback: rdata.callback,
                          argument: rdata.argument, last: 1'b0};
            held_valid_next = 1'b1;
          end
          if (keep) begin
            we          = 1'b1;
            wdata       = rdata;
            if (fire) wdata.last_time = now_q;
            wr_ptr_next = wr_ptr + 1'b1;
          end
          if (rd_ptr < count) begin
            re          = 1'b1;
            rd_ptr_next = rd_ptr + 1'b1;
          end else begin
            count_next = wr_ptr + CW'(keep);
            state_next = held_valid_next ? ST_FLUSH : ST_IDLE;
          end
        end
      end
      ST_FLUSH: begin
        res.last = 1'b1;
        if (out_free) begin
          push            = 1'b1;
          held_valid_next = 1'b0;
          state_next      = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  a_push_free: assert property (@(posedge clk) disable iff (rst) push |-> out_free)
    else $error("result pushed into a full output register");
  a_count_max: assert property (@(posedge clk) disable iff (rst) count <= CW'(MAX_TASKS))
    else $error("task count above table depth");
  a_compact: assert property (@(posedge clk) disable iff (rst)
      state == ST_SCAN |-> wr_ptr < rd_ptr)
    else $error("compaction write pointer passed read pointer");
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
      state == ST_IDLE |-> !held_valid)
    else $error("held result left behind in idle");
  a_res_limit: assert property (@(posedge clk) disable iff (rst)
      state == ST_SCAN |-> nres <= RW'(MaxResults))
    else $error("fired count above limit");

endmodule

// ===== src/interval_task_timer_table.sv =====
`timescale 1ns / 1ps
// interval_task_timer_table: top level, output register and halted register.
// Depends on itt_pkg, itt_in_if/itt_out_if and itt_core.
//
// - req carries one word per operation: add periodic, add once, add delayed
//   or tick (with the current time in now). rsp returns one word per insert
//   (accepted / rejected, last set) or one word per fired task on a tick,
//   last set on the final one. A tick that fires nothing returns no word.
// - cfg_wr_en / cfg_wr_data write the halted bit; write only while idle.
// - An insert writes the table entry in the accept cycle; ST_FLUSH then
//   moves the result into the output register once that register is free.
// - A tick scans the table in ST_SCAN, then passes through ST_FLUSH when
//   anything fired. The scan reads one entry per cycle, unless rsp stalls,
//   from the task memory (one read port, one write port) and writes
//   the previous entry back, compacted. A halted tick does nothing.
//   Fired words are held back one slot so that last can be set.
// - A new request is taken once the previous one has finished; its result
//   may still sit in the output register.
// - If rsp stalls, the scan holds on the next due task until the output
//   register frees up; nothing is dropped.
// - Reset (rst, synchronous) empties the table and clears halted; table
//   contents need no clearing pass.
module interval_task_timer_table #(
  parameter int MAX_TASKS = itt_pkg::MaxTasksDef
) (
  input  logic     clk,
  input  logic     rst,
  itt_in_if.sink   req,
  itt_out_if.source rsp,
  input  logic     cfg_wr_en,
  input  logic     cfg_wr_data
);
  import itt_pkg::*;

  logic    halted;
  logic    out_free;
  logic    push;
  result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      halted <= 1'b0;
    end else if (cfg_wr_en) begin
      halted <= cfg_wr_data;
    end
  end

  itt_core #(
    .MAX_TASKS (MAX_TASKS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .halted   (halted),
    .req      (req),
    .out_free (out_free),
    .push     (push),
    .res      (res)
  );

  // single output register; takes a new word when empty or being drained
  assign out_free = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (push) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
    if (push) begin
      rsp.result_kind    <= res.kind;
      rsp.fired_callback <= res.callback;
      rsp.fired_argument <= res.argument;
      rsp.last           <= res.last;
    end
  end

endmodule
